[design/assert_macros.svh]
// assert_macros.svh: assertion macros shared by the control word ALU modules.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CWA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define CWA_NEVER(label, clk, rst_n, cond, msg) \
    `CWA_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[design/cwa_pkg.sv]
// cwa_pkg: item types, opcode codes and constants for the control word ALU.
// No dependencies.
package cwa_pkg;

    localparam int DATA_W = 16;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    // ALU opcodes
    typedef enum logic [3:0] {
        OP_AND     = 4'd1,
        OP_OR      = 4'd2,
        OP_XOR     = 4'd3,
        OP_SHIFT_A = 4'd4,
        OP_ADD     = 4'd5,
        OP_SHIFT_B = 4'd6,
        OP_PASS_A  = 4'd7,
        OP_PASS_B  = 4'd8,
        OP_SUB     = 4'd9,
        OP_PASS_C  = 4'd10,
        OP_CMP     = 4'd11,
        OP_PASS_D  = 4'd13,
        OP_SHL8    = 4'd15
    } opcode_t;

    // control flag bit positions
    localparam int CF_IMM_ZEXT    = 0;
    localparam int CF_B_FROM_REG  = 1;
    localparam int CF_A_ZERO      = 2;
    localparam int CF_FORCE_TGT   = 3;
    localparam int CF_FORCE_ADDR  = 4;
    localparam int CF_FORCE_STORE = 5;
    localparam int CF_FORCE_WB    = 6;
    localparam int CF_LINK_WB     = 7;

    // compare flag codes
    localparam logic [1:0] FLG_GREATER = 2'd0;
    localparam logic [1:0] FLG_EQUAL   = 2'd1;
    localparam logic [1:0] FLG_LESS    = 2'd2;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [7:0]        control_flags;
        logic [7:0]        immediate;
        logic [DATA_W-1:0] reg_a;
        logic [DATA_W-1:0] reg_b;
        logic [DATA_W-1:0] link_value;
    } cwa_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] target;
        logic [1:0]        flags;
        logic [DATA_W-1:0] writeback;
        logic [DATA_W-1:0] mem_address;
        logic [DATA_W-1:0] store_data;
    } cwa_res_t;

    // handshake between the input register and the result register
    typedef struct packed {
        logic valid;
        logic ready;
    } cwa_hs_t;

endpackage

[design/cwa_cmd_if.sv]
// cwa_cmd_if: valid/ready channel carrying one command item.
// Depends on cwa_pkg.
interface cwa_cmd_if
    import cwa_pkg::*;
;
    logic     valid;
    logic     ready;
    cwa_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/cwa_res_if.sv]
// cwa_res_if: valid/ready channel carrying one result item.
// Depends on cwa_pkg.
interface cwa_res_if
    import cwa_pkg::*;
;
    logic     valid;
    logic     ready;
    cwa_res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/cwa_in_stage.sv]
// cwa_in_stage: input register holding the accepted command item.
// Depends on cwa_pkg, cwa_cmd_if and assert_macros.svh.
`include "assert_macros.svh"

module cwa_in_stage
    import cwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cwa_cmd_if.sink    cmd,
    input  logic       down_ready,
    output cwa_hs_t    hs,
    output cwa_cmd_t   item
);

    logic     valid_reg;
    logic     valid_next;
    cwa_cmd_t item_reg;
    logic     load;

    // take a new item when empty or when the held one moves on
    assign cmd.ready = !valid_reg || down_ready;
    assign load      = cmd.valid && cmd.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= cmd.data;
        end
    end

    assign hs.valid = valid_reg;
    assign hs.ready = down_ready;
    assign item     = item_reg;

    // a held item that is not taken stays in place
    `CWA_ASSERT(a_hold_item, clk, rst_n,
        valid_reg && !down_ready |=> valid_reg && $stable(item_reg),
        "input register lost a stalled item")
    // an accepted item always shows up as valid next cycle
    `CWA_ASSERT(a_load_valid, clk, rst_n, load |=> valid_reg, "accepted item not registered")

endmodule

[design/cwa_alu.sv]
// cwa_alu: operand selection, ALU, compare flags and output forcing.
// Depends on cwa_pkg.
module cwa_alu
    import cwa_pkg::*;
(
    input  cwa_cmd_t   item,
    input  logic [1:0] flags_cur,
    output cwa_res_t   res
);

    logic [DATA_W-1:0] imm_ext;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic [DATA_W-1:0] alu;
    logic [1:0]        flags_new;
    logic [3:0]        shamt;

    // operand muxes
    always_comb
    begin
        if (item.control_flags[CF_IMM_ZEXT])
        begin
            imm_ext = {{(DATA_W-8){1'b0}}, item.immediate};
        end
        else
        begin
            imm_ext = {{(DATA_W-8){item.immediate[7]}}, item.immediate};
        end
        opnd_b = item.control_flags[CF_B_FROM_REG] ? item.reg_b : imm_ext;
        opnd_a = item.control_flags[CF_A_ZERO] ? '0 : item.reg_a;
        shamt  = opnd_b[3:0];
    end

    // ALU and compare
    always_comb
    begin
        flags_new = flags_cur;
        unique case (opcode_t'(item.opcode))
            OP_AND:  alu = opnd_a & opnd_b;
            OP_OR:   alu = opnd_a | opnd_b;
            OP_XOR:  alu = opnd_a ^ opnd_b;
            OP_SHIFT_A, OP_SHIFT_B:
            begin
                // bit 3 of the amount picks the direction
                if (shamt[3])
                begin
                    alu = opnd_a >> shamt;
                end
                else
                begin
                    alu = opnd_a << shamt;
                end
            end
            OP_ADD:  alu = opnd_a + opnd_b;
            OP_SUB:  alu = opnd_a - opnd_b;
            OP_CMP:
            begin
                alu = opnd_a;
                if (opnd_a == opnd_b)
                begin
                    flags_new = FLG_EQUAL;
                end
                else if (opnd_a < opnd_b)
                begin
                    flags_new = FLG_LESS;
                end
                else
                begin
                    flags_new = FLG_GREATER;
                end
            end
            OP_SHL8: alu = {opnd_b[DATA_W-9:0], 8'h00};
            OP_PASS_A, OP_PASS_B, OP_PASS_C, OP_PASS_D: alu = opnd_b;
            default: alu = ALL_ONES;
        endcase
    end

    // output selection and forcing
    always_comb
    begin
        res.target = item.control_flags[CF_FORCE_TGT] ? ALL_ONES : opnd_a;
        res.flags  = flags_new;
        if (item.control_flags[CF_LINK_WB])
        begin
            res.writeback = item.link_value;
        end
        else if (item.control_flags[CF_FORCE_WB])
        begin
            res.writeback = ALL_ONES;
        end
        else
        begin
            res.writeback = alu;
        end
        res.mem_address = item.control_flags[CF_FORCE_ADDR] ? ALL_ONES : alu;
        res.store_data  = item.control_flags[CF_FORCE_STORE] ? ALL_ONES : opnd_a;
    end

endmodule

[design/cwa_out_stage.sv]
// cwa_out_stage: result register and the held compare flags.
// Depends on cwa_pkg, cwa_res_if and assert_macros.svh.
`include "assert_macros.svh"

module cwa_out_stage
    import cwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cwa_hs_t    hs,
    input  cwa_res_t   res_in,
    output logic       up_ready,
    output logic [1:0] flags_cur,
    cwa_res_if.source  res
);

    logic       valid_reg;
    logic       valid_next;
    cwa_res_t   res_reg;
    logic [1:0] flags_reg;
    logic       load;

    // room when empty or when the current result is being taken
    assign up_ready = !valid_reg || res.ready;
    assign load     = hs.valid && up_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // control state and compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= FLG_GREATER;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                flags_reg <= res_in.flags;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign flags_cur = flags_reg;
    assign res.valid = valid_reg;
    assign res.data  = res_reg;

    // held flags move only when an item passes into the result register
    `CWA_ASSERT(a_flags_on_load, clk, rst_n, !$stable(flags_reg) |-> $past(load),
        "compare flags changed without an item")
    `CWA_NEVER(a_flags_code, clk, rst_n, flags_reg == 2'd3, "illegal compare flag code")
    // the shown flags are the held flags after that item
    `CWA_ASSERT(a_flags_match, clk, rst_n, valid_reg |-> res_reg.flags == flags_reg,
        "result flags differ from held flags")

endmodule

[design/control_word_alu.sv]
// control_word_alu: top level of the 16-bit control word ALU.
// Depends on cwa_pkg, cwa_cmd_if, cwa_res_if, cwa_in_stage, cwa_alu, cwa_out_stage.
//
// Usage:
//   cmd  - command channel (valid/ready): opcode, control flags, immediate,
//          two register values and a link value, one item per instruction.
//   res  - result channel (valid/ready): target, compare flags, write-back,
//          memory address and store data, one result item per command item.
// An item is taken into an input register, worked on by one pass of
// combinational logic and caught in a result register, from which the
// receiver takes it. One item per cycle is sustained while the receiver
// takes every result; the single ALU pass between the two registers
// sets that figure.
// Reset clears both valid bits and the held compare flags to zero
// (greater). When the receiver stalls, the result register holds its item
// and the input register may still take one more item; after that cmd.ready
// drops until the result is taken. Compare flags change only as a compare
// item moves into the result register, so they follow item order exactly.
module control_word_alu
    import cwa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cwa_cmd_if.sink   cmd,
    cwa_res_if.source res
);

    cwa_hs_t    hs;
    cwa_cmd_t   item;
    cwa_res_t   res_comb;
    logic       up_ready;
    logic [1:0] flags_cur;

    cwa_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .down_ready (up_ready),
        .hs         (hs),
        .item       (item)
    );

    cwa_alu u_alu (
        .item      (item),
        .flags_cur (flags_cur),
        .res       (res_comb)
    );

    cwa_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .hs        (hs),
        .res_in    (res_comb),
        .up_ready  (up_ready),
        .flags_cur (flags_cur),
        .res       (res)
    );

endmodule

[tb/tb_control_word_alu.sv]
`timescale 1ns / 100ps
// tb_control_word_alu: self-checking testbench for the 16-bit control word ALU.
// Depends on cwa_pkg, cwa_cmd_if, cwa_res_if and control_word_alu.
module tb_control_word_alu
    import cwa_pkg::*;
;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    // opcodes with no operation behind them
    localparam logic [3:0] OP_UNDEF_0  = 4'd0;
    localparam logic [3:0] OP_UNDEF_12 = 4'd12;
    localparam logic [3:0] OP_UNDEF_14 = 4'd14;

    logic clk;
    logic rst_n;

    cwa_cmd_if cmd_ch ();
    cwa_res_if res_ch ();

    control_word_alu u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // predictor state and expected outputs
    logic [1:0] cmp_state;
    cwa_res_t   pending_outputs[$];

    int src_idle_pct;
    int sink_stall_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int error_count;
    int items_sent;
    int results_checked;
    int compares_seen;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // work out the outputs of one item, updating the held compare flags
    function automatic cwa_res_t compute_outputs(input cwa_cmd_t c);
        logic [DATA_W-1:0] imm_ext;
        logic [DATA_W-1:0] op_a;
        logic [DATA_W-1:0] op_b;
        logic [DATA_W-1:0] alu;
        cwa_res_t          r;
        imm_ext = c.control_flags[CF_IMM_ZEXT] ? {8'h00, c.immediate}
                                               : {{8{c.immediate[7]}}, c.immediate};
        op_b = c.control_flags[CF_B_FROM_REG] ? c.reg_b : imm_ext;
        op_a = c.control_flags[CF_A_ZERO] ? '0 : c.reg_a;
        case (c.opcode)
            OP_AND: alu = op_a & op_b;
            OP_OR:  alu = op_a | op_b;
            OP_XOR: alu = op_a ^ op_b;
            OP_SHIFT_A, OP_SHIFT_B:
                alu = op_b[3] ? (op_a >> op_b[3:0]) : (op_a << op_b[3:0]);
            OP_ADD: alu = op_a + op_b;
            OP_SUB: alu = op_a - op_b;
            OP_CMP:
            begin
                alu = op_a;
                compares_seen++;
                if (op_a == op_b)
                    cmp_state = FLG_EQUAL;
                else if (op_a < op_b)
                    cmp_state = FLG_LESS;
                else
                    cmp_state = FLG_GREATER;
            end
            OP_SHL8: alu = {op_b[7:0], 8'h00};
            OP_PASS_A, OP_PASS_B, OP_PASS_C, OP_PASS_D: alu = op_b;
            default: alu = ALL_ONES;
        endcase
        r.target      = c.control_flags[CF_FORCE_TGT] ? ALL_ONES : op_a;
        r.flags       = cmp_state;
        r.writeback   = c.control_flags[CF_LINK_WB] ? c.link_value :
                        c.control_flags[CF_FORCE_WB] ? ALL_ONES : alu;
        r.mem_address = c.control_flags[CF_FORCE_ADDR] ? ALL_ONES : alu;
        r.store_data  = c.control_flags[CF_FORCE_STORE] ? ALL_ONES : op_a;
        return r;
    endfunction

    function automatic logic [7:0] flag_bit(input int pos);
        return 8'(1) << pos;
    endfunction

    function automatic cwa_cmd_t make_cmd(input logic [3:0] op, input logic [7:0] cf,
                                          input logic [7:0] imm, input logic [15:0] ra,
                                          input logic [15:0] rb, input logic [15:0] link);
        cwa_cmd_t c;
        c.opcode        = op;
        c.control_flags = cf;
        c.immediate     = imm;
        c.reg_a         = ra;
        c.reg_b         = rb;
        c.link_value    = link;
        return c;
    endfunction

    // operand values leaning towards the corners
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cwa_cmd_t rand_cmd();
        cwa_cmd_t c;
        int       i;
        c.opcode                  = 4'($urandom_range(0, 15));
        c.control_flags[2:0]      = 3'($urandom_range(0, 7));
        // force and link bits set a quarter of the time so the ALU stays visible
        for (i = CF_FORCE_TGT; i <= CF_LINK_WB; i++)
            c.control_flags[i] = ($urandom_range(0, 3) == 0);
        c.immediate               = ($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom);
        c.reg_a                   = rand_word();
        c.reg_b                   = rand_word();
        c.link_value              = 16'($urandom);
        // steer some compares onto the equal case
        if (c.opcode == OP_CMP && $urandom_range(0, 3) == 0)
        begin
            c.control_flags[CF_B_FROM_REG] = 1'b1;
            c.reg_b = c.control_flags[CF_A_ZERO] ? 16'h0000 : c.reg_a;
        end
        return c;
    endfunction

    // send one item; starts and ends at a falling edge, valid left high
    task automatic send_item(input cwa_cmd_t c);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        pending_outputs.push_back(compute_outputs(c));
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and let every expected result arrive
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(input int count, input int src_pct, input int snk_pct);
        int n;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        for (n = 0; n < count; n++)
            send_item(rand_cmd());
        wait_for_results();
    endtask

    task automatic test_directed();
        cwa_cmd_t dir_items[$];
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        dir_items.push_back(make_cmd(OP_ADD, 8'h00, 8'h80, 16'h0001, 16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_ADD, flag_bit(CF_IMM_ZEXT), 8'h80, 16'h0001,
                                     16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_ADD, flag_bit(CF_B_FROM_REG), 8'h00, 16'hFFFF,
                                     16'h0001, 16'h0000));
        dir_items.push_back(make_cmd(OP_SUB, flag_bit(CF_B_FROM_REG), 8'h00, 16'h0000,
                                     16'h0001, 16'h0000));
        dir_items.push_back(make_cmd(OP_AND, flag_bit(CF_B_FROM_REG), 8'h00, 16'hA5A5,
                                     16'hFFFF, 16'h0000));
        dir_items.push_back(make_cmd(OP_OR, flag_bit(CF_B_FROM_REG) | flag_bit(CF_A_ZERO),
                                     8'h00, 16'hFFFF, 16'h5A5A, 16'h0000));
        dir_items.push_back(make_cmd(OP_XOR, flag_bit(CF_IMM_ZEXT), 8'hFF, 16'hFFFF,
                                     16'h0000, 16'h0000));
        // right shifts by 8 and 15, left shifts by 7 and 0
        dir_items.push_back(make_cmd(OP_SHIFT_A, flag_bit(CF_B_FROM_REG), 8'h00, 16'h8001,
                                     16'h0008, 16'h0000));
        dir_items.push_back(make_cmd(OP_SHIFT_B, flag_bit(CF_IMM_ZEXT), 8'h0F, 16'hFFFF,
                                     16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_SHIFT_A, flag_bit(CF_IMM_ZEXT), 8'h07, 16'hFFFF,
                                     16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_SHIFT_B, flag_bit(CF_IMM_ZEXT), 8'h00, 16'h1234,
                                     16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_SHL8, flag_bit(CF_IMM_ZEXT), 8'hFF, 16'h0000,
                                     16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_SHL8, flag_bit(CF_B_FROM_REG), 8'h00, 16'h0000,
                                     16'h1234, 16'h0000));
        dir_items.push_back(make_cmd(OP_PASS_A, 8'h00, 8'h7F, 16'h0000, 16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_PASS_B, 8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_PASS_C, flag_bit(CF_IMM_ZEXT), 8'hFF, 16'h0000,
                                     16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_PASS_D, flag_bit(CF_B_FROM_REG), 8'h00, 16'h0000,
                                     16'hFFFF, 16'h0000));
        // compares: equal, less, a held value across an add, then greater (unsigned)
        dir_items.push_back(make_cmd(OP_CMP, flag_bit(CF_B_FROM_REG), 8'h00, 16'h1234,
                                     16'h1234, 16'h0000));
        dir_items.push_back(make_cmd(OP_CMP, flag_bit(CF_B_FROM_REG), 8'h00, 16'h0000,
                                     16'hFFFF, 16'h0000));
        dir_items.push_back(make_cmd(OP_ADD, 8'h00, 8'h01, 16'h0001, 16'h0000, 16'h0000));
        dir_items.push_back(make_cmd(OP_CMP, flag_bit(CF_B_FROM_REG), 8'h00, 16'hFFFF,
                                     16'h0000, 16'h0000));
        // undefined opcodes with the output forcing and link options
        dir_items.push_back(make_cmd(OP_UNDEF_0, flag_bit(CF_FORCE_TGT) | flag_bit(CF_FORCE_ADDR),
                                     8'h00, 16'h1111, 16'h2222, 16'h3333));
        dir_items.push_back(make_cmd(OP_UNDEF_12,
                                     flag_bit(CF_FORCE_STORE) | flag_bit(CF_FORCE_WB),
                                     8'h00, 16'h1111, 16'h2222, 16'h3333));
        dir_items.push_back(make_cmd(OP_UNDEF_14, flag_bit(CF_LINK_WB) | flag_bit(CF_FORCE_WB),
                                     8'h00, 16'h1111, 16'h2222, 16'hBEEF));
        dir_items.push_back(make_cmd(OP_CMP, 8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'h0000));
        foreach (dir_items[i])
            send_item(dir_items[i]);
        wait_for_results();
    endtask

    task automatic test_streaming();
        run_random(500, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random(420, 46, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random(420, 0, 46);
    endtask

    task automatic test_both_idle();
        run_random(420, 18, 18);
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        int rnd;
        int n;
        src_idle_pct   = 0;
        sink_stall_pct = 20;
        for (rnd = 0; rnd < 3; rnd++)
        begin
            @(posedge clk);
            hold_request = 80;
            @(negedge clk);
            for (n = 0; n < 50; n++)
                send_item(rand_cmd());
            wait_for_results();
        end
    endtask

    // receiver ready, with random stalls and the long hold-off
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected 0x%04h, got 0x%04h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        cwa_res_t exp_res;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result item with no expectation waiting");
                error_count++;
            end
            else
            begin
                exp_res = pending_outputs.pop_front();
                check_field("target", exp_res.target, res_ch.data.target);
                check_field("flags", 16'(exp_res.flags), 16'(res_ch.data.flags));
                check_field("writeback", exp_res.writeback, res_ch.data.writeback);
                check_field("mem_address", exp_res.mem_address, res_ch.data.mem_address);
                check_field("store_data", exp_res.store_data, res_ch.data.store_data);
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.data     = '0;
        res_ch.ready    = 1'b0;
        cmp_state       = FLG_GREATER;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_request    = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        compares_seen   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();

        $display("Run covered %0d items (%0d compares) and checked %0d results,",
                 items_sent, compares_seen, results_checked);
        $display("with directed corners, idle and stall mixes and long receiver hold-offs.");
        if (error_count == 0 && pending_outputs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
